@@ sv/ptum_pkg.sv @@
// types and constants shared by the utilization monitor
`timescale 1ns / 1ps

package ptum_pkg;

  localparam int unsigned NUM_PROC_DEFAULT = 64;

  localparam int unsigned TS_W       = 64;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned THR_W      = 12;
  localparam int unsigned MP_W       = 8;
  localparam int unsigned SHARE_W    = 16;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned IN_DATA_W  = 152;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned MUL_B_W    = MP_W + THR_W;
  localparam int unsigned MUL_P_W    = 32 + MUL_B_W;
  localparam int unsigned DEN_W      = TS_W + MUL_B_W;
  localparam int unsigned WALK_MAX   = 2 ** IDX_W;

  localparam logic [MP_W-1:0]  MP_RESET  = 8'd1;
  localparam logic [THR_W-1:0] THR_RESET = 12'd1024;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MP_COUNT    = 1'b0,
    REG_MAX_THREADS = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    OP_TASK   = 1'b0,
    OP_REPORT = 1'b1
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_ACC,
    ST_WRITE,
    ST_DMUL,
    ST_DSUM,
    ST_SCAN,
    ST_LOAD,
    ST_DIV,
    ST_EMIT,
    ST_CLEAR
  } state_e;

endpackage

@@ sv/per_task_utilization_monitor_top.sv @@
// top level of the per-procedure utilization monitor
//
// channel  | dir | fields (low bit first)
// s_axis   | in  | tdata: start stamp, end stamp, proc_index, active_threads; tuser: opcode;
//          |     | tlast: batch_last
// m_axis   | out | tdata: report_index, share; tlast: report_last
// cfg      | in  | we, addr (0 mp_count, 1 max_threads_per_mp), data
//
// task record: ram read at accept, then prod, acc, write; the input reopens after write
// report tick: denominator in the dmul and dsum states, then a scan step per index, plus
//   for a seen index a ram read, the 16-step divider and the output load, or no divide
//   when the share needs none, then a clear step; ends at the last seen
// a full output register holds the report walk at its output load; the input stays
//   closed until the walk has finished
// reset is immediate, no clearing pass: areas and seen marks are held as flop valid bits
`timescale 1ns / 1ps

module per_task_utilization_monitor_top #(
  parameter int unsigned NumProcedures = ptum_pkg::NUM_PROC_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // start stamp, end stamp, proc_index, active_threads, zero pad
  input  logic [ptum_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // opcode
  input  logic                                s_axis_tuser,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // report_index, share, zero pad
  output logic [ptum_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast,
  input  logic                                cfg_we_i,
  input  logic [ptum_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [ptum_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned Walk = (NumProcedures < ptum_pkg::WALK_MAX) ?
                                 NumProcedures : ptum_pkg::WALK_MAX;
  localparam int unsigned AW = $clog2(Walk);
  localparam logic [AW-1:0] WalkLast = AW'(Walk - 1);
  localparam int unsigned TW = ptum_pkg::TS_W;
  localparam int unsigned DW = ptum_pkg::DEN_W;

  // input unpacking
  logic [TW-1:0]                 in_start;
  logic [TW-1:0]                 in_end;
  logic [ptum_pkg::IDX_W-1:0]    in_idx;
  logic [ptum_pkg::THR_W-1:0]    in_thr;
  logic                          in_acc;
  logic                          in_report;
  logic                          in_range;
  logic [TW:0]                   in_diff;

  assign in_start  = s_axis_tdata[63:0];
  assign in_end    = s_axis_tdata[127:64];
  assign in_idx    = s_axis_tdata[133:128];
  assign in_thr    = s_axis_tdata[145:134];
  assign in_acc    = s_axis_tvalid & s_axis_tready;
  assign in_report = (ptum_pkg::opcode_e'(s_axis_tuser) == ptum_pkg::OP_REPORT);
  assign in_range  = ({1'b0, in_idx} < (ptum_pkg::IDX_W + 1)'(Walk));
  assign in_diff   = {1'b0, in_end} - {1'b0, in_start};

  ptum_pkg::state_e state_q, state_d;

  logic [ptum_pkg::MP_W-1:0]    mp_q, mp_d;
  logic [ptum_pkg::THR_W-1:0]   maxth_q, maxth_d;
  logic [Walk-1:0]              seen_q, seen_d;
  logic [Walk-1:0]              avld_q, avld_d;
  logic [TW-1:0]                ct_q, ct_d;
  logic [TW-1:0]                bmax_q, bmax_d;
  logic [TW-1:0]                bmin_q, bmin_d;
  logic [AW-1:0]                walk_q, walk_d;
  logic [3:0]                   cnt_q, cnt_d;
  logic                         out_vld_q, out_vld_d;

  logic [AW-1:0]                idx_q, idx_d;
  logic                         inr_q, inr_d;
  logic                         last_q, last_d;
  logic [ptum_pkg::THR_W-1:0]   thr_q, thr_d;
  logic [TW-1:0]                delta_q, delta_d;
  logic [ptum_pkg::MUL_B_W-1:0] m_q, m_d;
  logic [ptum_pkg::MUL_P_W-1:0] p0_q, p0_d;
  logic [ptum_pkg::MUL_P_W-1:0] p1_q, p1_d;
  logic [DW-1:0]                sum_q, sum_d;
  logic [TW-1:0]                span_q, span_d;
  logic [DW-1:0]                rem_q, rem_d;
  logic [ptum_pkg::SHARE_W-1:0] quo_q, quo_d;
  logic [ptum_pkg::IDX_W-1:0]   out_idx_q, out_idx_d;
  logic [ptum_pkg::SHARE_W-1:0] out_share_q, out_share_d;
  logic                         out_last_q, out_last_d;

  // ram
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [TW-1:0] mem_wdata;
  logic [TW-1:0] mem_rdata;

  ptum_ram #(
    .Width(TW),
    .Depth(Walk)
  ) u_area_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(idx_q),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // shared datapath pieces
  logic [AW-1:0]                area_sel;
  logic [TW-1:0]                area_cur;
  logic [TW-1:0]                mul_a;
  logic [ptum_pkg::MUL_B_W-1:0] mul_b;
  logic [TW-1:0]                prod_sat;
  logic [TW:0]                  area_add;
  logic [TW:0]                  ct_add;
  logic [TW:0]                  span_diff;
  logic                         den_zero;
  logic                         area_ge;
  logic [DW:0]                  rem_sh;
  logic [DW+1:0]                trial;
  logic                         trial_ge;
  logic [Walk-1:0]              above;
  logic                         more_seen;
  logic                         out_free;
  logic                         out_load;

  assign area_sel  = (state_q == ptum_pkg::ST_WRITE) ? idx_q : walk_q;
  assign area_cur  = avld_q[area_sel] ? mem_rdata : '0;
  assign mul_a     = (state_q == ptum_pkg::ST_DMUL) ? ct_q : delta_q;
  assign mul_b     = (state_q == ptum_pkg::ST_DMUL) ? m_q : ptum_pkg::MUL_B_W'(thr_q);
  assign prod_sat  = (|sum_q[DW-1:TW]) ? '1 : sum_q[TW-1:0];
  assign area_add  = {1'b0, area_cur} + {1'b0, prod_sat};
  assign ct_add    = {1'b0, ct_q} + {1'b0, span_q};
  assign span_diff = {1'b0, bmax_q} - {1'b0, bmin_q};
  assign den_zero  = (sum_q == '0);
  assign area_ge   = (DW'(area_cur) >= sum_q);
  assign rem_sh    = {rem_q, 1'b0};
  assign trial     = (DW + 2)'(rem_sh) - (DW + 2)'(sum_q);
  assign trial_ge  = ~trial[DW+1];
  assign out_free  = ~out_vld_q | m_axis_tready;
  assign out_load  = (state_q == ptum_pkg::ST_EMIT) && out_free;
  assign mem_wdata = area_add[TW] ? '1 : area_add[TW-1:0];

  always_comb begin
    for (int j = 0; j < Walk; j++) begin
      above[j] = (AW'(j) > walk_q);
    end
  end

  assign more_seen = |(seen_q & above);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ptum_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = in_report ? ptum_pkg::ST_DMUL : ptum_pkg::ST_PROD;
        end
      end
      ptum_pkg::ST_PROD:  state_d = ptum_pkg::ST_ACC;
      ptum_pkg::ST_ACC:   state_d = ptum_pkg::ST_WRITE;
      ptum_pkg::ST_WRITE: state_d = ptum_pkg::ST_IDLE;
      ptum_pkg::ST_DMUL:  state_d = ptum_pkg::ST_DSUM;
      ptum_pkg::ST_DSUM:  state_d = ptum_pkg::ST_SCAN;
      ptum_pkg::ST_SCAN: begin
        if (seen_q[walk_q]) begin
          state_d = ptum_pkg::ST_LOAD;
        end else if (walk_q == WalkLast) begin
          state_d = ptum_pkg::ST_CLEAR;
        end
      end
      ptum_pkg::ST_LOAD: begin
        state_d = (den_zero || area_ge) ? ptum_pkg::ST_EMIT : ptum_pkg::ST_DIV;
      end
      ptum_pkg::ST_DIV: begin
        if (cnt_q == 4'd15) begin
          state_d = ptum_pkg::ST_EMIT;
        end
      end
      ptum_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = more_seen ? ptum_pkg::ST_SCAN : ptum_pkg::ST_CLEAR;
        end
      end
      ptum_pkg::ST_CLEAR: state_d = ptum_pkg::ST_IDLE;
      default:            state_d = ptum_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    mp_d        = mp_q;
    maxth_d     = maxth_q;
    seen_d      = seen_q;
    avld_d      = avld_q;
    ct_d        = ct_q;
    bmax_d      = bmax_q;
    bmin_d      = bmin_q;
    walk_d      = walk_q;
    cnt_d       = cnt_q;
    out_vld_d   = out_vld_q;
    idx_d       = idx_q;
    inr_d       = inr_q;
    last_d      = last_q;
    thr_d       = thr_q;
    delta_d     = delta_q;
    m_d         = m_q;
    p0_d        = p0_q;
    p1_d        = p1_q;
    sum_d       = sum_q;
    span_d      = span_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    out_idx_d   = out_idx_q;
    out_share_d = out_share_q;
    out_last_d  = out_last_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = walk_q;

    if (cfg_we_i) begin
      case (ptum_pkg::cfg_reg_e'(cfg_addr_i))
        ptum_pkg::REG_MP_COUNT:    mp_d = cfg_data_i[ptum_pkg::MP_W-1:0];
        ptum_pkg::REG_MAX_THREADS: maxth_d = cfg_data_i;
        default: ;
      endcase
    end

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ptum_pkg::ST_IDLE: begin
        if (in_acc && in_report) begin
          m_d    = mp_q * maxth_q;
          walk_d = '0;
        end else if (in_acc) begin
          idx_d   = in_idx[AW-1:0];
          inr_d   = in_range;
          last_d  = s_axis_tlast;
          thr_d   = in_thr;
          delta_d = in_diff[TW] ? '0 : in_diff[TW-1:0];
          mem_re  = in_range;
          mem_raddr = in_idx[AW-1:0];
          if (in_end > bmax_q) begin
            bmax_d = in_end;
          end
          if (in_start < bmin_q) begin
            bmin_d = in_start;
          end
        end
      end
      ptum_pkg::ST_PROD, ptum_pkg::ST_DMUL: begin
        p0_d = mul_a[31:0] * mul_b;
        p1_d = mul_a[63:32] * mul_b;
        if (state_q == ptum_pkg::ST_PROD && last_q) begin
          span_d = span_diff[TW] ? '0 : span_diff[TW-1:0];
          bmax_d = '0;
          bmin_d = '1;
        end
      end
      ptum_pkg::ST_ACC, ptum_pkg::ST_DSUM: begin
        sum_d = {p1_q, 32'b0} + DW'(p0_q);
        if (state_q == ptum_pkg::ST_ACC && last_q) begin
          ct_d = ct_add[TW] ? '1 : ct_add[TW-1:0];
        end
      end
      ptum_pkg::ST_WRITE: begin
        if (inr_q) begin
          mem_we         = 1'b1;
          seen_d[idx_q]  = 1'b1;
          avld_d[idx_q]  = 1'b1;
        end
      end
      ptum_pkg::ST_SCAN: begin
        if (seen_q[walk_q]) begin
          mem_re = 1'b1;
        end else if (walk_q != WalkLast) begin
          walk_d = walk_q + AW'(1);
        end
      end
      ptum_pkg::ST_LOAD: begin
        if (den_zero) begin
          quo_d = '0;
        end else if (area_ge) begin
          quo_d = '1;
        end else begin
          rem_d = DW'(area_cur);
          quo_d = '0;
          cnt_d = '0;
        end
      end
      ptum_pkg::ST_DIV: begin
        rem_d = trial_ge ? trial[DW-1:0] : rem_sh[DW-1:0];
        quo_d = {quo_q[ptum_pkg::SHARE_W-2:0], trial_ge};
        cnt_d = cnt_q + 4'd1;
      end
      ptum_pkg::ST_EMIT: begin
        if (out_free) begin
          out_vld_d   = 1'b1;
          out_idx_d   = ptum_pkg::IDX_W'(walk_q);
          out_share_d = quo_q;
          out_last_d  = ~more_seen;
          if (more_seen) begin
            walk_d = walk_q + AW'(1);
          end
        end
      end
      ptum_pkg::ST_CLEAR: begin
        avld_d = '0;
        ct_d   = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ptum_pkg::ST_IDLE;
      mp_q      <= ptum_pkg::MP_RESET;
      maxth_q   <= ptum_pkg::THR_RESET;
      seen_q    <= '0;
      avld_q    <= '0;
      ct_q      <= '0;
      bmax_q    <= '0;
      bmin_q    <= '1;
      walk_q    <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      mp_q      <= mp_d;
      maxth_q   <= maxth_d;
      seen_q    <= seen_d;
      avld_q    <= avld_d;
      ct_q      <= ct_d;
      bmax_q    <= bmax_d;
      bmin_q    <= bmin_d;
      walk_q    <= walk_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    inr_q       <= inr_d;
    last_q      <= last_d;
    thr_q       <= thr_d;
    delta_q     <= delta_d;
    m_q         <= m_d;
    p0_q        <= p0_d;
    p1_q        <= p1_d;
    sum_q       <= sum_d;
    span_q      <= span_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    out_idx_q   <= out_idx_d;
    out_share_q <= out_share_d;
    out_last_q  <= out_last_d;
  end

  assign s_axis_tready = (state_q == ptum_pkg::ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_share_q, out_idx_q};
  assign m_axis_tlast  = out_last_q;

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != ptum_pkg::ST_IDLE)
    else $error("accepted item did not start work");

  a_write_marks_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> seen_q[$past(idx_q)])
    else $error("area written without seen mark");

  a_emit_only_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> seen_q[walk_q])
    else $error("share emitted for unseen index");

  a_div_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ptum_pkg::ST_DIV |-> rem_q < sum_q)
    else $error("divider remainder out of range");

endmodule

@@ sv/ptum_ram.sv @@
// generic single-write single-read ram with registered read data
`timescale 1ns / 1ps

module ptum_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ verif/per_task_utilization_monitor_top_test.sv @@
// self-checking testbench for the per-procedure utilization monitor
`timescale 1ns / 1ps

module per_task_utilization_monitor_top_test;
  import ptum_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned PHASE_ITEMS = 70;
  localparam int unsigned NUM_PHASES = 6;

  typedef struct packed {
    opcode_e          op;
    logic [TS_W-1:0]  t_start;
    logic [TS_W-1:0]  t_end;
    logic [IDX_W-1:0] proc;
    logic [THR_W-1:0] thr;
    logic             last;
  } task_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [SHARE_W-1:0] share;
    logic               last;
  } share_t;

  typedef struct packed {
    opcode_e            op;
    logic [TS_W-1:0]    t_start;
    logic [TS_W-1:0]    t_end;
    logic [IDX_W-1:0]   proc;
    logic [THR_W-1:0]   thr;
    logic               last;
    bit                 typed;
    bit                 t_cnt;
    logic [IDX_W-1:0]   t_idx;
    logic [SHARE_W-1:0] t_share;
  } row_t;

  localparam logic [TS_W-1:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  // typed rows hold at most one seen procedure, so their single share is known
  localparam row_t DIRECTED [18] = '{
    '{OP_REPORT, ONES, ONES, 6'd63, 12'hFFF, 1'b1, 1'b1, 1'b0, 6'd0, 16'd0},
    '{OP_TASK, 64'd0, ONES, 6'd63, 12'd2048, 1'b1, 1'b0, 1'b0, 6'd0, 16'd0},
    '{OP_TASK, 64'd0, ONES, 6'd63, 12'd2048, 1'b1, 1'b0, 1'b0, 6'd0, 16'd0},
    '{OP_REPORT, 64'd0, 64'd0, 6'd0, 12'd0, 1'b0, 1'b1, 1'b1, 6'd63, 16'd64},
    '{OP_TASK, 64'd10, 64'd20, 6'd63, 12'd1, 1'b0, 1'b0, 1'b0, 6'd0, 16'd0},
    '{OP_REPORT, 64'd7, 64'd3, 6'd1, 12'd9, 1'b1, 1'b1, 1'b1, 6'd63, 16'd0},
    '{OP_TASK, 64'd5, 64'd15, 6'd63, 12'd1024, 1'b1, 1'b0, 1'b0, 6'd0, 16'd0},
    '{OP_REPORT, 64'd0, 64'd0, 6'd0, 12'd0, 1'b0, 1'b0, 1'b0, 6'd0, 16'd0},
    '{OP_TASK, 64'd0, 64'd100, 6'd63, 12'd2048, 1'b1, 1'b0, 1'b0, 6'd0, 16'd0},
    '{OP_REPORT, ONES, 64'd0, 6'd5, 12'd5, 1'b0, 1'b1, 1'b1, 6'd63, 16'hFFFF},
    '{OP_TASK, 64'd1000, 64'd10, 6'd0, 12'd7, 1'b1, 1'b0, 1'b0, 6'd0, 16'd0},
    '{OP_TASK, ONES, 64'd0, 6'd32, 12'd2048, 1'b0, 1'b0, 1'b0, 6'd0, 16'd0},
    '{OP_TASK, 64'd3, 64'h1_0000_0000, 6'd21, 12'd0, 1'b1, 1'b0, 1'b0, 6'd0, 16'd0},
    '{OP_REPORT, 64'h1234, ONES, 6'd63, 12'd2048, 1'b1, 1'b0, 1'b0, 6'd0, 16'd0},
    '{OP_TASK, 64'h8000_0000_0000_0000, 64'h8000_0100_0000_0000, 6'd42, 12'h555, 1'b0,
      1'b0, 1'b0, 6'd0, 16'd0},
    '{OP_TASK, 64'h8000_0000_0000_1000, 64'h8000_0000_0200_0000, 6'd42, 12'h2AA, 1'b1,
      1'b0, 1'b0, 6'd0, 16'd0},
    '{OP_TASK, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 6'h2A, 12'h7FF, 1'b1,
      1'b0, 1'b0, 6'd0, 16'd0},
    '{OP_REPORT, 64'd0, 64'd0, 6'd0, 12'd0, 1'b0, 1'b0, 1'b0, 6'd0, 16'd0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // start stamp, end stamp, proc_index, active_threads, zero pad
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  // opcode
  logic                  s_axis_tuser;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // report_index, share, zero pad
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // predictor state
  logic [TS_W-1:0]  area_acc [NUM_PROC_DEFAULT];
  bit               seen_mark [NUM_PROC_DEFAULT];
  logic [TS_W-1:0]  cycle_acc;
  logic [TS_W-1:0]  span_end;
  logic [TS_W-1:0]  span_start;
  logic [MP_W-1:0]  mp_cfg;
  logic [THR_W-1:0] thr_cfg;

  share_t      pending_shares [$];
  int unsigned fail_count;
  int unsigned src_idle;
  int unsigned sink_idle;
  longint      cycle_count;

  per_task_utilization_monitor_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void predict_record(input task_item_t it);
    logic [TS_W-1:0] delta;
    logic [TS_W-1:0] prod_sat;
    logic [TS_W-1:0] span;
    logic [TS_W+THR_W-1:0] prod;
    logic [TS_W:0] sum;
    delta = (it.t_end > it.t_start) ? it.t_end - it.t_start : '0;
    prod = (TS_W+THR_W)'(delta) * (TS_W+THR_W)'(it.thr);
    prod_sat = (|prod[TS_W+THR_W-1:TS_W]) ? '1 : prod[TS_W-1:0];
    sum = {1'b0, area_acc[it.proc]} + {1'b0, prod_sat};
    area_acc[it.proc] = sum[TS_W] ? '1 : sum[TS_W-1:0];
    seen_mark[it.proc] = 1'b1;
    if (it.t_end > span_end) span_end = it.t_end;
    if (it.t_start < span_start) span_start = it.t_start;
    if (it.last) begin
      span = (span_end > span_start) ? span_end - span_start : '0;
      sum = {1'b0, cycle_acc} + {1'b0, span};
      cycle_acc = sum[TS_W] ? '1 : sum[TS_W-1:0];
      span_end = '0;
      span_start = '1;
    end
  endfunction

  function automatic void predict_report(output share_t shares[$]);
    logic [DEN_W-1:0] den;
    logic [DEN_W+SHARE_W-1:0] quot;
    share_t s;
    shares = {};
    den = DEN_W'(cycle_acc) * DEN_W'(mp_cfg) * DEN_W'(thr_cfg);
    for (int i = 0; i < NUM_PROC_DEFAULT; i++) begin
      if (seen_mark[i]) begin
        s.idx = IDX_W'(i);
        s.last = 1'b0;
        if (den == '0) begin
          s.share = '0;
        end else if (DEN_W'(area_acc[i]) >= den) begin
          s.share = '1;
        end else begin
          quot = ((DEN_W+SHARE_W)'(area_acc[i]) << SHARE_W) / (DEN_W+SHARE_W)'(den);
          s.share = quot[SHARE_W-1:0];
        end
        shares = {shares, s};
      end
    end
    if (shares.size() > 0) shares[shares.size()-1].last = 1'b1;
    foreach (area_acc[i]) area_acc[i] = '0;
    cycle_acc = '0;
  endfunction

  task automatic send_item(input task_item_t it, input bit typed = 1'b0,
                           input bit t_cnt = 1'b0, input logic [IDX_W-1:0] t_idx = '0,
                           input logic [SHARE_W-1:0] t_share = '0);
    share_t shares [$];
    share_t one;
    while ($urandom_range(0, 99) < src_idle) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {6'd0, it.thr, it.proc, it.t_end, it.t_start};
    s_axis_tuser  = it.op;
    s_axis_tlast  = it.last;
    do @(posedge clk_i); while (!s_axis_tready);
    if (it.op == OP_TASK) begin
      predict_record(it);
    end else begin
      predict_report(shares);
      if (typed) begin
        shares = {};
        if (t_cnt) begin
          one = '{t_idx, t_share, 1'b1};
          shares = {shares, one};
        end
      end
      pending_shares = {pending_shares, shares};
    end
    @(negedge clk_i);
  endtask

  task automatic write_cfg(input cfg_reg_e sel, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   = 1'b1;
    cfg_addr_i = sel;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (sel == REG_MP_COUNT) mp_cfg = val[MP_W-1:0];
    else thr_cfg = val[THR_W-1:0];
  endtask

  task automatic drain_and_settle();
    s_axis_tvalid = 1'b0;
    while (pending_shares.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // receiver back-pressure
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready = ($urandom_range(0, 99) >= sink_idle);
    end
  end

  always @(posedge clk_i) begin
    share_t got;
    share_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[IDX_W-1:0], m_axis_tdata[IDX_W+SHARE_W-1:IDX_W], m_axis_tlast};
      if (pending_shares.size() == 0) begin
        $display("%0t: unexpected item idx %0d share %0d last %0b", $time,
                 got.idx, got.share, got.last);
        fail_count++;
      end else begin
        want = pending_shares.pop_front();
        if (got.idx !== want.idx || got.share !== want.share || got.last !== want.last) begin
          $display("%0t: expected idx %0d share %0d last %0b, got idx %0d share %0d last %0b",
                   $time, want.idx, want.share, want.last, got.idx, got.share, got.last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    task_item_t it;
    int unsigned n;
    int unsigned nrec;
    int unsigned r;
    bit paused;
    logic [TS_W-1:0] base;
    cycle_count   = 0;
    fail_count    = 0;
    src_idle      = 37;
    sink_idle     = 72;
    paused        = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = REG_MP_COUNT;
    cfg_data_i    = '0;
    foreach (area_acc[i]) begin
      area_acc[i]  = '0;
      seen_mark[i] = 1'b0;
    end
    cycle_acc  = '0;
    span_end   = '0;
    span_start = '1;
    mp_cfg     = MP_RESET;
    thr_cfg    = THR_RESET;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED[k]) begin
      it = '{DIRECTED[k].op, DIRECTED[k].t_start, DIRECTED[k].t_end, DIRECTED[k].proc,
             DIRECTED[k].thr, DIRECTED[k].last};
      send_item(it, DIRECTED[k].typed, DIRECTED[k].t_cnt, DIRECTED[k].t_idx,
                DIRECTED[k].t_share);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      src_idle  = (p < 2) ? 37 : (p < 4) ? 72 : 0;
      sink_idle = (p < 2) ? 72 : (p < 4) ? 37 : 0;
      if (p > 0) begin
        drain_and_settle();
        case (p)
          1: begin
            write_cfg(REG_MP_COUNT, 12'd255);
            write_cfg(REG_MAX_THREADS, 12'd2048);
          end
          2: begin
            write_cfg(REG_MP_COUNT, 12'd1);
            write_cfg(REG_MAX_THREADS, 12'd1);
          end
          3: begin
            write_cfg(REG_MAX_THREADS, 12'd2048);
          end
          4: begin
            write_cfg(REG_MP_COUNT, 12'd255);
            write_cfg(REG_MAX_THREADS, 12'd1);
          end
          default: begin
            write_cfg(REG_MP_COUNT, 12'($urandom_range(1, 255)));
            write_cfg(REG_MAX_THREADS, 12'($urandom_range(1, 2048)));
          end
        endcase
      end
      n = 0;
      while (n < PHASE_ITEMS) begin
        if (p == 3 && !paused && n >= PHASE_ITEMS / 2) begin
          // hold the stream until the report backlog is empty
          s_axis_tvalid = 1'b0;
          while (pending_shares.size() != 0) @(negedge clk_i);
          paused = 1'b1;
        end
        r = $urandom_range(0, 99);
        if (r < 15) begin
          it = '{OP_REPORT, {$urandom(), $urandom()}, {$urandom(), $urandom()},
                 6'($urandom()), 12'($urandom()), 1'($urandom())};
          send_item(it);
          n++;
        end else if (r < 30) begin
          it = '{OP_TASK, {$urandom(), $urandom()}, {$urandom(), $urandom()},
                 6'($urandom()), 12'($urandom_range(0, 2048)), 1'($urandom())};
          send_item(it);
          n++;
        end else begin
          case ($urandom_range(0, 2))
            0: base = 64'($urandom_range(0, 1000));
            1: base = {$urandom(), $urandom()};
            default: base = ONES - 64'($urandom_range(0, 20000));
          endcase
          nrec = $urandom_range(1, 6);
          for (int k = 0; k < nrec; k++) begin
            it.op      = OP_TASK;
            it.t_start = base + 64'($urandom_range(0, 4000));
            it.t_end   = it.t_start + 64'($urandom_range(0, 4000));
            it.proc    = 6'($urandom());
            it.thr     = ($urandom_range(0, 9) == 0) ? 12'd2048
                                                     : 12'($urandom_range(0, thr_cfg));
            it.last    = (k == nrec - 1);
            send_item(it);
            n++;
          end
        end
      end
      it = '{OP_REPORT, '0, '0, '0, '0, 1'b0};
      send_item(it);
    end

    s_axis_tvalid = 1'b0;
    while (pending_shares.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ per_task_utilization_monitor_top.f @@
sv/ptum_pkg.sv
sv/ptum_ram.sv
sv/per_task_utilization_monitor_top.sv
verif/per_task_utilization_monitor_top_test.sv
